// ===== design/csi_pkg.sv =====
package csi_pkg;

  // Slice width for the wide-by-t multipliers
  localparam int CHUNK_W = 32;

  // Guard bits of the power-basis coefficients over the point width
  localparam int COEF_XW = 5;

  // Curve mode codes
  typedef enum logic [1:0] {
    FUNC_LINEAR  = 2'd0,
    FUNC_BEZIER  = 2'd1,
    FUNC_HERMITE = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

endpackage

// ===== design/cubic_spline_interpolate_core.sv =====
// Evaluates one component of a linear, cubic Bezier or Catmull-Rom segment per
// word, using exact power-basis Horner evaluation in t. The pipeline is eight
// register stages deep (coefficient stage, three Horner steps of two stages
// each, and a round/saturate output register), and one word is taken every
// cycle while the output side keeps up. Each Horner step's wide-by-t product is
// split into 32-bit slices whose products are registered before being summed.
// Mode 3 returns zero without the saturation flag; t above one is taken as one.
module cubic_spline_interpolate_core #(
  parameter int POINT_WIDTH     = 32,
  parameter int BLEND_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic signed [POINT_WIDTH-1:0] point_0_i,
  input  logic signed [POINT_WIDTH-1:0] point_1_i,
  input  logic signed [POINT_WIDTH-1:0] point_2_i,
  input  logic signed [POINT_WIDTH-1:0] point_3_i,
  input  logic [BLEND_FRAC_BITS:0]      blend_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [POINT_WIDTH-1:0] value_o,
  output logic                          saturated_o
);

  localparam int CW  = POINT_WIDTH + csi_pkg::COEF_XW;
  localparam int TB  = BLEND_FRAC_BITS + 1;
  localparam int AW3 = CW;
  localparam int AW2 = CW + TB;
  localparam int AW1 = CW + 2 * TB;
  localparam int AW0 = CW + 3 * TB;
  localparam int LAT = 8;
  localparam int OW  = $clog2(LAT + 1);

  // Coefficient stage
  logic                 cf_valid, cf_ready;
  logic signed [CW-1:0] c0, c1, c2, c3;
  logic [TB-1:0]        cf_t;
  logic                 cf_none;

  csi_coef #(
    .POINT_WIDTH    (POINT_WIDTH),
    .BLEND_FRAC_BITS(BLEND_FRAC_BITS)
  ) u_coef (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .func_i   (func_i),
    .point_0_i(point_0_i),
    .point_1_i(point_1_i),
    .point_2_i(point_2_i),
    .point_3_i(point_3_i),
    .blend_i  (blend_i),
    .valid_o  (cf_valid),
    .ready_i  (cf_ready),
    .c0_o     (c0),
    .c1_o     (c1),
    .c2_o     (c2),
    .c3_o     (c3),
    .t_o      (cf_t),
    .none_o   (cf_none)
  );

  // Horner step: c3 * t + c2 * one
  logic                  s3_valid, s3_ready;
  logic signed [AW2-1:0] s3_a;
  logic [TB-1:0]         s3_t;
  logic [2*CW:0]         s3_pass;

  csi_tmul #(
    .AW             (AW3),
    .BLEND_FRAC_BITS(BLEND_FRAC_BITS),
    .CW             (CW),
    .ADD_SHIFT      (BLEND_FRAC_BITS),
    .PASS_W         (2 * CW + 1)
  ) u_step3 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(cf_valid),
    .ready_o(cf_ready),
    .a_i    (c3),
    .t_i    (cf_t),
    .add_i  (c2),
    .pass_i ({cf_none, c1, c0}),
    .valid_o(s3_valid),
    .ready_i(s3_ready),
    .a_o    (s3_a),
    .t_o    (s3_t),
    .pass_o (s3_pass)
  );

  // Horner step: previous * t + c1 * one^2
  logic                  s2_valid, s2_ready;
  logic signed [AW1-1:0] s2_a;
  logic [TB-1:0]         s2_t;
  logic [CW:0]           s2_pass;

  csi_tmul #(
    .AW             (AW2),
    .BLEND_FRAC_BITS(BLEND_FRAC_BITS),
    .CW             (CW),
    .ADD_SHIFT      (2 * BLEND_FRAC_BITS),
    .PASS_W         (CW + 1)
  ) u_step2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s3_valid),
    .ready_o(s3_ready),
    .a_i    (s3_a),
    .t_i    (s3_t),
    .add_i  ($signed(s3_pass[2*CW-1:CW])),
    .pass_i ({s3_pass[2*CW], s3_pass[CW-1:0]}),
    .valid_o(s2_valid),
    .ready_i(s2_ready),
    .a_o    (s2_a),
    .t_o    (s2_t),
    .pass_o (s2_pass)
  );

  // Horner step: previous * t + c0 * one^3
  logic                  s1_valid, s1_ready;
  logic signed [AW0-1:0] s1_a;
  logic                  s1_none;

  csi_tmul #(
    .AW             (AW1),
    .BLEND_FRAC_BITS(BLEND_FRAC_BITS),
    .CW             (CW),
    .ADD_SHIFT      (3 * BLEND_FRAC_BITS),
    .PASS_W         (1)
  ) u_step1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s2_valid),
    .ready_o(s2_ready),
    .a_i    (s2_a),
    .t_i    (s2_t),
    .add_i  ($signed(s2_pass[CW-1:0])),
    .pass_i (s2_pass[CW]),
    .valid_o(s1_valid),
    .ready_i(s1_ready),
    .a_o    (s1_a),
    .t_o    (),
    .pass_o (s1_none)
  );

  // Round, saturate, output register
  csi_round #(
    .POINT_WIDTH    (POINT_WIDTH),
    .BLEND_FRAC_BITS(BLEND_FRAC_BITS)
  ) u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_valid),
    .ready_o    (s1_ready),
    .a_i        (s1_a),
    .none_i     (s1_none),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .value_o    (value_o),
    .saturated_o(saturated_o)
  );

  // Words in flight, for the checks below
  logic [OW-1:0] occ_q, occ_d;
  logic          in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    case ({in_acc, out_acc})
      2'b10:   occ_d = occ_q + OW'(1);
      2'b01:   occ_d = occ_q - OW'(1);
      default: occ_d = occ_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  localparam logic signed [POINT_WIDTH-1:0] VMAX = {1'b0, {(POINT_WIDTH-1){1'b1}}};
  localparam logic signed [POINT_WIDTH-1:0] VMIN = {1'b1, {(POINT_WIDTH-1){1'b0}}};

  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> (value_o == VMAX) || (value_o == VMIN))
    else $error("saturated word not on a rail");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occ_q != '0)
    else $error("output word with nothing in flight");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(LAT))
    else $error("more words in flight than pipeline stages");

endmodule

// ===== design/csi_coef.sv =====
module csi_coef #(
  parameter int POINT_WIDTH     = 32,
  parameter int BLEND_FRAC_BITS = 16,
  localparam int CW = POINT_WIDTH + csi_pkg::COEF_XW,
  localparam int TB = BLEND_FRAC_BITS + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [1:0]                    func_i,
  input  logic signed [POINT_WIDTH-1:0] point_0_i,
  input  logic signed [POINT_WIDTH-1:0] point_1_i,
  input  logic signed [POINT_WIDTH-1:0] point_2_i,
  input  logic signed [POINT_WIDTH-1:0] point_3_i,
  input  logic [TB-1:0]                 blend_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic signed [CW-1:0]          c0_o,
  output logic signed [CW-1:0]          c1_o,
  output logic signed [CW-1:0]          c2_o,
  output logic signed [CW-1:0]          c3_o,
  output logic [TB-1:0]                 t_o,
  output logic                          none_o
);

  localparam logic [TB-1:0] ONE = TB'(1) << BLEND_FRAC_BITS;

  logic signed [CW-1:0] p0, p1, p2, p3;
  logic signed [CW-1:0] d12, d01, e2;
  logic signed [CW-1:0] c0_d, c1_d, c2_d, c3_d;
  logic signed [CW-1:0] c0_q, c1_q, c2_q, c3_q;
  logic [TB-1:0]        t_d, t_q;
  logic                 none_d, none_q;
  logic                 valid_q;
  logic                 load;

  assign p0 = CW'(point_0_i);
  assign p1 = CW'(point_1_i);
  assign p2 = CW'(point_2_i);
  assign p3 = CW'(point_3_i);

  assign d12 = p1 - p2;
  assign d01 = p1 - p0;
  assign e2  = p0 - (p1 <<< 1) + p2;

  // Power-basis coefficients; linear and Bezier are doubled so that every
  // mode shares the same final shift as the Hermite form
  always_comb begin
    c0_d   = '0;
    c1_d   = '0;
    c2_d   = '0;
    c3_d   = '0;
    none_d = 1'b0;
    unique case (func_i)
      csi_pkg::FUNC_LINEAR: begin
        c1_d = (p3 - p0) <<< 1;
        c0_d = p0 <<< 1;
      end
      csi_pkg::FUNC_BEZIER: begin
        c3_d = (p3 - p0 + (d12 <<< 1) + d12) <<< 1;
        c2_d = (e2 <<< 2) + (e2 <<< 1);
        c1_d = (d01 <<< 2) + (d01 <<< 1);
        c0_d = p0 <<< 1;
      end
      csi_pkg::FUNC_HERMITE: begin
        c3_d = (d12 <<< 1) + d12 + p3 - p0;
        c2_d = (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
        c1_d = p2 - p0;
        c0_d = p1 <<< 1;
      end
      default: begin
        none_d = 1'b1;
      end
    endcase
  end

  // t is clamped to exactly one
  assign t_d = (blend_i > ONE) ? ONE : blend_i;

  // Stage handshake
  assign load    = !valid_q || ready_i;
  assign ready_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      c0_q   <= c0_d;
      c1_q   <= c1_d;
      c2_q   <= c2_d;
      c3_q   <= c3_d;
      t_q    <= t_d;
      none_q <= none_d;
    end
  end

  assign valid_o = valid_q;
  assign c0_o    = c0_q;
  assign c1_o    = c1_q;
  assign c2_o    = c2_q;
  assign c3_o    = c3_q;
  assign t_o     = t_q;
  assign none_o  = none_q;

endmodule

// ===== design/csi_tmul.sv =====
// One Horner step: a_o = a_i * t + (add_i << ADD_SHIFT), two register stages.
// The first stage forms slice products of a_i by t, the second sums them.
module csi_tmul #(
  parameter int AW              = 37,
  parameter int BLEND_FRAC_BITS = 16,
  parameter int CW              = 37,
  parameter int ADD_SHIFT       = 16,
  parameter int PASS_W          = 1,
  localparam int TB = BLEND_FRAC_BITS + 1,
  localparam int RW = AW + TB
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [AW-1:0] a_i,
  input  logic [TB-1:0]        t_i,
  input  logic signed [CW-1:0] add_i,
  input  logic [PASS_W-1:0]    pass_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [RW-1:0] a_o,
  output logic [TB-1:0]        t_o,
  output logic [PASS_W-1:0]    pass_o
);

  localparam int CK  = csi_pkg::CHUNK_W;
  localparam int NCH = (AW + CK - 1) / CK;
  localparam int TW  = AW - CK * (NCH - 1);
  localparam int XW  = CK + 1;
  localparam int PPW = XW + TB + 1;
  localparam int SW  = CK * (NCH - 1) + PPW;

  logic signed [PPW-1:0] pp_d [NCH];
  logic signed [PPW-1:0] pp_q [NCH];
  logic signed [CW-1:0]  add_q;
  logic [TB-1:0]         t1_q, t2_q;
  logic [PASS_W-1:0]     pass1_q, pass2_q;
  logic                  v1_q, v2_q;
  logic                  load1, load2;
  logic signed [SW-1:0]  sum;
  logic signed [RW-1:0]  a_d, a_q;

  // Slice products; the top slice carries the sign
  for (genvar i = 0; i < NCH; i++) begin : g_chunk
    logic signed [XW-1:0] slice_x;
    if (i < NCH - 1) begin : g_lo
      assign slice_x = signed'({1'b0, a_i[CK*i +: CK]});
    end else begin : g_top
      assign slice_x = signed'({{(XW-TW){a_i[AW-1]}}, a_i[AW-1 -: TW]});
    end
    assign pp_d[i] = slice_x * signed'({1'b0, t_i});
  end

  // Handshake for the two stages
  assign load2   = !v2_q || ready_i;
  assign load1   = !v1_q || load2;
  assign ready_o = load1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (load1) v1_q <= valid_i;
      if (load2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load1 && valid_i) begin
      pp_q    <= pp_d;
      add_q   <= add_i;
      t1_q    <= t_i;
      pass1_q <= pass_i;
    end
  end

  // Recombine slices and add the aligned coefficient
  always_comb begin
    sum = SW'(add_q) <<< ADD_SHIFT;
    for (int i = 0; i < NCH; i++) begin
      sum = sum + (SW'(pp_q[i]) <<< (CK * i));
    end
  end

  assign a_d = sum[RW-1:0];

  always_ff @(posedge clk_i) begin
    if (load2 && v1_q) begin
      a_q     <= a_d;
      t2_q    <= t1_q;
      pass2_q <= pass1_q;
    end
  end

  assign valid_o = v2_q;
  assign a_o     = a_q;
  assign t_o     = t2_q;
  assign pass_o  = pass2_q;

endmodule

// ===== design/csi_round.sv =====
// Final rounding shift (half up) and saturation to the point range.
module csi_round #(
  parameter int POINT_WIDTH     = 32,
  parameter int BLEND_FRAC_BITS = 16,
  localparam int CW = POINT_WIDTH + csi_pkg::COEF_XW,
  localparam int AW = CW + 3 * (BLEND_FRAC_BITS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [AW-1:0]          a_i,
  input  logic                          none_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic signed [POINT_WIDTH-1:0] value_o,
  output logic                          saturated_o
);

  localparam int RS = 3 * BLEND_FRAC_BITS + 1;
  localparam int QW = AW - RS;
  localparam logic signed [POINT_WIDTH-1:0] VMAX = {1'b0, {(POINT_WIDTH-1){1'b1}}};
  localparam logic signed [POINT_WIDTH-1:0] VMIN = {1'b1, {(POINT_WIDTH-1){1'b0}}};

  logic signed [AW-1:0]          rnd;
  logic [QW-1:0]                 q;
  logic [QW-POINT_WIDTH:0]       hi;
  logic                          fits;
  logic signed [POINT_WIDTH-1:0] value_d, value_q;
  logic                          sat_d, sat_q;
  logic                          valid_q;
  logic                          load;

  // Add half an output LSB, then floor
  assign rnd  = a_i + (AW'(1) <<< (RS - 1));
  assign q    = rnd[AW-1:RS];
  assign hi   = q[QW-1:POINT_WIDTH-1];
  assign fits = (&hi) || !(|hi);

  always_comb begin
    if (none_i) begin
      value_d = '0;
    end else if (fits) begin
      value_d = q[POINT_WIDTH-1:0];
    end else if (q[QW-1]) begin
      value_d = VMIN;
    end else begin
      value_d = VMAX;
    end
  end

  assign sat_d = !none_i && !fits;

  // Output register
  assign load    = !valid_q || ready_i;
  assign ready_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      value_q <= value_d;
      sat_q   <= sat_d;
    end
  end

  assign valid_o     = valid_q;
  assign value_o     = value_q;
  assign saturated_o = sat_q;

endmodule

// ===== tb/sv/tb.sv =====
module tb;

  localparam int PW = 32;
  localparam int BF = 16;
  localparam int BLEND_ONE = 1 << BF;
  localparam int N_RANDOM = 1500;
  localparam logic signed [PW-1:0] P_MAX = 32'sh7fff_ffff;
  localparam logic signed [PW-1:0] P_MIN = 32'sh8000_0000;

  // one input word and one result word
  typedef struct {
    csi_pkg::func_e        func;
    logic signed [PW-1:0]  p0;
    logic signed [PW-1:0]  p1;
    logic signed [PW-1:0]  p2;
    logic signed [PW-1:0]  p3;
    logic [BF:0]           blend;
    bit                    drain;  // hold this word back until all results are in
  } curve_word_t;

  typedef struct {
    logic signed [PW-1:0] value;
    logic                 saturated;
  } curve_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] func_i = csi_pkg::FUNC_LINEAR;
  logic signed [PW-1:0] point_0_i = '0;
  logic signed [PW-1:0] point_1_i = '0;
  logic signed [PW-1:0] point_2_i = '0;
  logic signed [PW-1:0] point_3_i = '0;
  logic [BF:0] blend_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [PW-1:0] value_o;
  logic saturated_o;

  curve_word_t word_q[$];   // words waiting to be offered
  curve_res_t  curve_q[$];  // predicted results, oldest first
  curve_word_t cur_w;
  int words_total = 0;
  int words_sent = 0;
  int words_got = 0;
  int bad_cnt = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  logic [31:0] sink_cyc = '0;
  logic hold_off = 1'b0;

  cubic_spline_interpolate_core #(
    .POINT_WIDTH    (PW),
    .BLEND_FRAC_BITS(BF)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .point_0_i  (point_0_i),
    .point_1_i  (point_1_i),
    .point_2_i  (point_2_i),
    .point_3_i  (point_3_i),
    .blend_i    (blend_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o),
    .saturated_o(saturated_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Exact curve evaluation: full-width sums, round half up, saturate
  function automatic curve_res_t curve_eval(curve_word_t w);
    logic signed [127:0] p0, p1, p2, p3, t, s, o, acc;
    int sh;
    curve_res_t r;
    p0 = 128'(w.p0);
    p1 = 128'(w.p1);
    p2 = 128'(w.p2);
    p3 = 128'(w.p3);
    t = (w.blend > (BF + 1)'(BLEND_ONE)) ? 128'(BLEND_ONE) : 128'(w.blend);
    o = 128'(BLEND_ONE);
    s = o - t;
    r.value = '0;
    r.saturated = 1'b0;
    case (w.func)
      csi_pkg::FUNC_LINEAR: begin
        acc = p0 * s + p3 * t;
        sh = BF;
      end
      csi_pkg::FUNC_BEZIER: begin
        acc = p0 * s * s * s + 3 * p1 * s * s * t + 3 * p2 * s * t * t + p3 * t * t * t;
        sh = 3 * BF;
      end
      csi_pkg::FUNC_HERMITE: begin
        acc = 2 * p1 * o * o * o + (p2 - p0) * t * o * o
            + (2 * p0 - 5 * p1 + 4 * p2 - p3) * t * t * o
            + (3 * p1 - 3 * p2 + p3 - p0) * t * t * t;
        sh = 3 * BF + 1;
      end
      default: return r;  // unused mode answers zero
    endcase
    acc = (acc + (128'sd1 <<< (sh - 1))) >>> sh;
    if (acc > 128'sd2147483647) begin
      r.value = P_MAX;
      r.saturated = 1'b1;
    end else if (acc < -128'sd2147483648) begin
      r.value = P_MIN;
      r.saturated = 1'b1;
    end else begin
      r.value = acc[PW-1:0];
    end
    return r;
  endfunction

  function automatic void add_word(csi_pkg::func_e f, logic signed [PW-1:0] a,
                                   logic signed [PW-1:0] b,
                                   logic signed [PW-1:0] c, logic signed [PW-1:0] d,
                                   int t, bit drain);
    curve_word_t w;
    w.func = f;
    w.p0 = a;
    w.p1 = b;
    w.p2 = c;
    w.p3 = d;
    w.blend = (BF + 1)'(t);
    w.drain = drain;
    word_q.push_back(w);
    words_total++;
  endfunction

  function automatic logic signed [PW-1:0] pick_point();
    case ($urandom_range(0, 7))
      0: return P_MAX;
      1: return P_MIN;
      2: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
      default: return $urandom;
    endcase
  endfunction

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic busy;
    logic took;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      func_i <= csi_pkg::FUNC_LINEAR;
      point_0_i <= '0;
      point_1_i <= '0;
      point_2_i <= '0;
      point_3_i <= '0;
      blend_i <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      busy = in_valid_i;
      took = in_valid_i && in_ready_o;
      if (took) begin
        curve_q.push_back(curve_eval(cur_w));
        words_sent <= words_sent + 1;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (word_q.size() > 0 &&
                     !(word_q[0].drain && (took || words_sent != words_got))) begin
          cur_w = word_q.pop_front();
          busy = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_valid_i <= busy;
      if (busy) begin
        func_i <= cur_w.func;
        point_0_i <= cur_w.p0;
        point_1_i <= cur_w.p1;
        point_2_i <= cur_w.p2;
        point_3_i <= cur_w.p3;
        blend_i <= cur_w.blend;
      end
    end
  end

  // Receiver: the stall pattern is redrawn whenever its random run length ends
  always @(posedge clk_i or negedge rst_ni) begin : sink
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
      stall_mode = 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 160);
      end else begin
        stall_left--;
      end
      sink_cyc = sink_cyc + 1;
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) == 1);
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= (sink_cyc % 5) != 0;
        endcase
      end
    end
  end

  // Long receiver hold-off so the pipeline backs up into the input
  initial begin
    wait (words_sent >= 300);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk_i) begin : check
    curve_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_got <= words_got + 1;
      if (curve_q.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10)
          $display("unexpected result word: value %h sat %b", value_o, saturated_o);
      end else begin
        want = curve_q.pop_front();
        if (want.value !== value_o || want.saturated !== saturated_o) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("mismatch: expected value %h sat %b, got value %h sat %b",
                     want.value, want.saturated, value_o, saturated_o);
        end
      end
    end
  end

  initial begin : main
    logic signed [PW-1:0] pt[4];
    logic signed [PW-1:0] base;
    int t;
    csi_pkg::func_e f;
    int sp;
    int i;
    int k;

    // directed words
    add_word(csi_pkg::FUNC_LINEAR, 0, 32'sh0001_0000, 5, 32'sh0001_0000, 0, 1'b0);
    add_word(csi_pkg::FUNC_LINEAR, 0, 7, 9, 32'sh0001_0000, BLEND_ONE, 1'b0);
    // rounds half up to one
    add_word(csi_pkg::FUNC_LINEAR, 1, 0, 0, 0, BLEND_ONE / 2, 1'b0);
    // rounds half up to zero
    add_word(csi_pkg::FUNC_LINEAR, -1, 0, 0, 0, BLEND_ONE / 2, 1'b0);
    add_word(csi_pkg::FUNC_LINEAR, P_MAX, P_MIN, P_MAX, P_MIN, BLEND_ONE / 2, 1'b0);
    add_word(csi_pkg::FUNC_LINEAR, P_MIN, P_MAX, P_MIN, P_MIN, BLEND_ONE - 1, 1'b0);
    // t above one
    add_word(csi_pkg::FUNC_LINEAR, P_MAX, 0, 0, P_MAX, 2 * BLEND_ONE - 1, 1'b0);
    add_word(csi_pkg::FUNC_BEZIER, P_MAX, P_MAX, P_MAX, P_MAX, BLEND_ONE / 2, 1'b0);
    add_word(csi_pkg::FUNC_BEZIER, 0, P_MAX, P_MAX, 0, BLEND_ONE / 2, 1'b0);
    add_word(csi_pkg::FUNC_BEZIER, P_MIN, P_MAX, P_MIN, P_MAX, 0, 1'b0);
    add_word(csi_pkg::FUNC_BEZIER, P_MIN, P_MAX, P_MIN, P_MAX, BLEND_ONE, 1'b0);
    add_word(csi_pkg::FUNC_BEZIER, P_MIN, P_MIN, P_MIN, P_MIN, 2 * BLEND_ONE - 1, 1'b0);
    add_word(csi_pkg::FUNC_BEZIER, 3, -7, 11, -13, 1, 1'b0);
    // overshoot high
    add_word(csi_pkg::FUNC_HERMITE, P_MIN, P_MAX, P_MAX, P_MIN, BLEND_ONE / 2, 1'b0);
    // overshoot low
    add_word(csi_pkg::FUNC_HERMITE, P_MAX, P_MIN, P_MIN, P_MAX, BLEND_ONE / 2, 1'b0);
    add_word(csi_pkg::FUNC_HERMITE, P_MIN, 32'sh1234_5678, P_MAX, 0, 0, 1'b0);
    add_word(csi_pkg::FUNC_HERMITE, P_MIN, 32'sh1234_5678, -32'sh0bad_cafe, 0,
             BLEND_ONE, 1'b0);
    add_word(csi_pkg::FUNC_HERMITE, 100, -200, 300, -400, 12345, 1'b0);
    add_word(csi_pkg::FUNC_HERMITE, 5, 6, 7, 8, BLEND_ONE + 1, 1'b0);
    // unused mode gives zero
    add_word(csi_pkg::FUNC_NONE, P_MAX, P_MIN, -1, 1, BLEND_ONE / 3, 1'b0);
    add_word(csi_pkg::FUNC_NONE, -1, -1, -1, -1, 2 * BLEND_ONE - 1, 1'b1);

    // random words, mostly coherent curves with some wild points
    for (i = 0; i < N_RANDOM; i++) begin
      f = ($urandom_range(0, 15) == 0) ? csi_pkg::FUNC_NONE
                                       : csi_pkg::func_e'($urandom_range(0, 2));
      if ($urandom_range(0, 9) < 6) begin
        base = $signed($urandom) >>> $urandom_range(0, 8);
        sp = 1 << $urandom_range(4, 24);
        for (k = 0; k < 4; k++)
          pt[k] = base + (int'($urandom_range(0, 2 * sp)) - sp);
      end else begin
        for (k = 0; k < 4; k++)
          pt[k] = pick_point();
      end
      case ($urandom_range(0, 9))
        0: t = $urandom_range(BLEND_ONE + 1, 2 * BLEND_ONE - 1);
        1: t = $urandom_range(0, 1) ? BLEND_ONE - $urandom_range(0, 1) : $urandom_range(0, 1);
        default: t = $urandom_range(0, BLEND_ONE);
      endcase
      add_word(f, pt[0], pt[1], pt[2], pt[3], t, (i == 500) || (i == 1000));
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    wait (words_sent == words_total);
    wait (words_got == words_sent);
    repeat (30) @(posedge clk_i);
    if (bad_cnt == 0 && curve_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (curve_q.size() != 0)
        $display("%0d predicted results never arrived", curve_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #8000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
